>>> rtl/pate_pkg.sv
// Shared types and codes for the positional array table engine.
package pate_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 3;
  localparam int FILL_W    = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_DEL,
    S_SCAN,
    S_SCAN_END,
    S_FINISH
  } state_t;

endpackage

>>> rtl/pate_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/positional_array_table_engine.sv
// Top level of the positional array table engine: command sequencer around the entry RAM.
//
// One command is taken at a time; in_stall is low only while the sequencer is idle, and a
// finished result may still wait in the output register while the next command is taken.
// The entries sit in one RAM with one read and one write port, and every walk moves one
// entry per cycle through that read port while the result side does not stall the walk.
// Commands 5 to 7 are taken and dropped.
module positional_array_table_engine #(
  parameter int DEPTH = pate_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [pate_pkg::CMD_W-1:0]  in_command,
  input  logic        [pate_pkg::POS_W-1:0]  in_position,
  input  logic signed [pate_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [pate_pkg::STAT_W-1:0] out_status,
  output logic        [pate_pkg::POS_W-1:0]  out_index,
  output logic signed [pate_pkg::VAL_W-1:0]  out_data,
  output logic        [pate_pkg::FILL_W-1:0] out_fill,
  output logic                               out_last
);

  import pate_pkg::*;

  localparam logic [FILL_W-1:0] CAP = FILL_W'(DEPTH);

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [VAL_W-1:0]    key_r, key_nxt;
  logic                dump_r, dump_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [POS_W-1:0]    res_index_r, res_index_nxt;
  logic [VAL_W-1:0]    res_data_r, res_data_nxt;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [POS_W-1:0]    out_index_r;
  logic [VAL_W-1:0]    out_data_r;
  logic [FILL_W-1:0]   out_fill_r;
  logic                out_last_r;

  logic                ld;
  logic [STAT_W-1:0]   ld_status;
  logic [POS_W-1:0]    ld_index;
  logic [VAL_W-1:0]    ld_data;
  logic                ld_last;
  logic                out_free;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [VAL_W-1:0]    ram_rdata;

  logic [FILL_W-1:0]   ptr_ext;
  logic                at_end;
  logic                match;
  logic                need_out;

  pate_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign ptr_ext  = FILL_W'(ptr_r);
  assign at_end   = (ptr_ext + 7'd1) == count_r;
  assign match    = ram_rdata == key_r;
  assign need_out = match && hit_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    dump_nxt       = dump_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_data_nxt   = res_data_r;
    ld             = 1'b0;
    ld_status      = ST_OK;
    ld_index       = '0;
    ld_data        = '0;
    ld_last        = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt        = in_position;
          key_nxt        = in_value;
          dump_nxt       = (in_command == CMD_DUMP);
          hit_nxt        = 1'b0;
          res_status_nxt = ST_OK;
          res_index_nxt  = '0;
          res_data_nxt   = '0;
          unique case (in_command) inside
            CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_FINISH;
            end
            CMD_INSERT: begin
              if (count_r >= CAP) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_FINISH;
              end else if ({1'b0, in_position} > count_r) begin
                res_status_nxt = ST_BADPOS;
                state_nxt      = S_FINISH;
              end else if ({1'b0, in_position} == count_r) begin
                state_nxt = S_INS_PUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(count_r - 7'd1);
                ptr_nxt   = AW'(count_r - 7'd1);
                state_nxt = S_INS;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FINISH;
              end else if ({1'b0, in_position} >= count_r) begin
                res_status_nxt = ST_BADPOS;
                state_nxt      = S_FINISH;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_position);
                ptr_nxt   = AW'(in_position);
                state_nxt = S_DEL;
              end
            end
            CMD_SEARCH, CMD_DUMP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FINISH;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r + AW'(1);
        if (ptr_ext == {1'b0, pos_r}) begin
          state_nxt = S_INS_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r - AW'(1);
          ptr_nxt   = ptr_r - AW'(1);
        end
      end
      S_INS_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = AW'(pos_r);
        ram_wdata      = key_r;
        count_nxt      = count_r + 7'd1;
        res_status_nxt = ST_OK;
        res_index_nxt  = pos_r;
        res_data_nxt   = key_r;
        state_nxt      = S_FINISH;
      end
      S_DEL: begin
        if (ptr_ext == {1'b0, pos_r}) begin
          res_data_nxt = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_r - AW'(1);
        end
        if (!at_end) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end else begin
          count_nxt      = count_r - 7'd1;
          res_status_nxt = ST_OK;
          res_index_nxt  = pos_r;
          state_nxt      = S_FINISH;
        end
      end
      S_SCAN: begin
        if (dump_r ? out_free : (!need_out || out_free)) begin
          if (dump_r) begin
            ld       = 1'b1;
            ld_index = POS_W'(ptr_r);
            ld_data  = ram_rdata;
            ld_last  = at_end;
          end else begin
            if (need_out) begin
              ld       = 1'b1;
              ld_index = POS_W'(hit_idx_r);
              ld_data  = key_r;
              ld_last  = 1'b0;
            end
            if (match) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = ptr_r;
            end
          end
          if (at_end) begin
            state_nxt = dump_r ? S_IDLE : S_SCAN_END;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r + AW'(1);
            ptr_nxt   = ptr_r + AW'(1);
          end
        end
      end
      S_SCAN_END: begin
        if (out_free) begin
          ld = 1'b1;
          if (hit_r) begin
            ld_index = POS_W'(hit_idx_r);
            ld_data  = key_r;
          end else begin
            ld_status = ST_NOMATCH;
          end
          state_nxt = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = res_status_r;
          ld_index  = res_index_r;
          ld_data   = res_data_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= ld || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    dump_r       <= dump_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_data_r   <= res_data_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_index_r  <= ld_index;
      out_data_r   <= ld_data;
      out_fill_r   <= count_r;
      out_last_r   <= ld_last;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_data   = out_data_r;
  assign out_fill   = out_fill_r;
  assign out_last   = out_last_r;

endmodule

>>> rtl/pate_checker.sv
// Port-level assertions for the positional array table engine, bound to the top level.
module pate_checker #(
  parameter int DEPTH = pate_pkg::DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic        [pate_pkg::CMD_W-1:0]  in_command,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic        [pate_pkg::STAT_W-1:0] out_status,
  input logic        [pate_pkg::POS_W-1:0]  out_index,
  input logic signed [pate_pkg::VAL_W-1:0]  out_data,
  input logic        [pate_pkg::FILL_W-1:0] out_fill,
  input logic                               out_last
);

  import pate_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_index)
      && $stable(out_data) && $stable(out_fill) && $stable(out_last))
    else $error("stalled result word changed");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last && (out_index == '0) && (out_data == '0))
    else $error("error result word not alone or not zeroed");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill <= FILL_W'(DEPTH)) && ((out_status != ST_EMPTY) || (out_fill == '0)))
    else $error("fill count out of range");

  a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command > CMD_DUMP) |=> !in_stall)
    else $error("unassigned command held the input");

endmodule

bind positional_array_table_engine pate_checker #(.DEPTH(DEPTH)) u_pate_checker (.*);
